// File: rtl/tun_pkg.sv
// triangle unit normal: shared widths, payload types and queue depths
// no dependencies; used by every module of the block except tun_fifo
package tun_pkg;

   localparam int COORD_WIDTH      = 16;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int OUT_WIDTH        = NORMAL_FRAC_BITS + 2;

   localparam int EDGE_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MAG_W   = CROSS_W;
   localparam int LEN_W   = $clog2(MAG_W + 1);
   localparam int SCALE_W = 31;
   localparam int SQ_W    = 2 * SCALE_W;
   localparam int SUM_W   = 64;
   localparam int ROOT_W  = SUM_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int NUM_W   = ROOT_W + NORMAL_FRAC_BITS;
   localparam int Q_W     = NORMAL_FRAC_BITS + 1;

   localparam int MID_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] a_x;
      logic signed [COORD_WIDTH-1:0] a_y;
      logic signed [COORD_WIDTH-1:0] a_z;
      logic signed [COORD_WIDTH-1:0] b_x;
      logic signed [COORD_WIDTH-1:0] b_y;
      logic signed [COORD_WIDTH-1:0] b_z;
      logic signed [COORD_WIDTH-1:0] c_x;
      logic signed [COORD_WIDTH-1:0] c_y;
      logic signed [COORD_WIDTH-1:0] c_z;
   } tun_req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] normal_x;
      logic signed [OUT_WIDTH-1:0] normal_y;
      logic signed [OUT_WIDTH-1:0] normal_z;
      logic                        degenerate;
   } tun_rsp_type;

   typedef struct packed {
      logic signed [CROSS_W-1:0] n_x;
      logic signed [CROSS_W-1:0] n_y;
      logic signed [CROSS_W-1:0] n_z;
   } tun_cross_type;

   // handshake between a stage group and the queue it feeds
   typedef struct packed {
      logic full;
      logic pop;
   } tun_sink_type;

endpackage

// File: rtl/triangle_unit_normal_core.sv
// Unit face normal of one triangle per clock as long as results are popped.
// The front end forms both edge vectors and the exact cross product through
// edge and product registers and drops it into a four-entry queue; the back
// end scales the cross product, squares and sums it, takes the square root
// one bit per stage over 32 stages and divides each component one quotient
// bit per stage over NORMAL_FRAC_BITS + 1 stages. Both halves are fully
// pipelined, so one triangle is accepted every cycle as long as results are
// popped; a zero cross product gives the zero vector with degenerate set.
//
// top level; depends on tun_pkg, tun_front, tun_back and tun_fifo
module triangle_unit_normal_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tun_pkg::tun_req_type req_data,
   output logic                 full,
   output logic                 empty,
   input  logic                 pop,
   output tun_pkg::tun_rsp_type rsp_data
);
   import tun_pkg::*;

   tun_sink_type  mid_sink;
   tun_cross_type mid_in, mid_out;
   tun_rsp_type   rsp_in;
   logic          mid_push, mid_empty, back_en, rsp_push, rsp_full;
   logic [$bits(tun_rsp_type)-1:0] rsp_raw;

   tun_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .sink     (mid_sink),
      .mid_push (mid_push),
      .mid_data (mid_in)
   );

   tun_fifo #(
      .WIDTH ($bits(tun_cross_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in),
      .full      (mid_sink.full),
      .pop       (mid_sink.pop),
      .pop_data  (mid_out),
      .empty     (mid_empty)
   );

   // the back end moves whenever its last stage has somewhere to go
   assign back_en = !rsp_full || pop;

   tun_back u_back (
      .clock    (clock),
      .reset    (reset),
      .en       (back_en),
      .in_vld   (!mid_empty),
      .in_data  (mid_out),
      .in_take  (mid_sink.pop),
      .out_push (rsp_push),
      .out_data (rsp_in)
   );

   tun_fifo #(
      .WIDTH ($bits(tun_rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (pop && !empty),
      .pop_data  (rsp_raw),
      .empty     (empty)
   );

   assign rsp_data = tun_rsp_type'(rsp_raw);

endmodule

// File: rtl/tun_fifo.sv
// small register queue with first-word fall-through read
// no package dependencies; width and depth set by the instantiating module
module tun_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

endmodule

// File: rtl/tun_front.sv
// front end: edge vectors and exact integer cross product
// depends on tun_pkg; feeds the middle queue
module tun_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tun_pkg::tun_req_type  req_data,
   output logic                  full,
   input  tun_pkg::tun_sink_type sink,
   output logic                  mid_push,
   output tun_pkg::tun_cross_type mid_data
);
   import tun_pkg::*;

   logic en;
   logic v1_ff, v2_ff;
   logic signed [EDGE_W-1:0] e0_ff [3], e0_in [3], e1_ff [3], e1_in [3];
   logic signed [PROD_W-1:0] p_ff [6], p_in [6];
   logic signed [COORD_WIDTH-1:0] va [3], vb [3], vc [3];

   assign en       = !v2_ff || !sink.full || sink.pop;
   assign full     = !en;
   assign mid_push = en && v2_ff;

   always_comb begin
      va = '{req_data.a_x, req_data.a_y, req_data.a_z};
      vb = '{req_data.b_x, req_data.b_y, req_data.b_z};
      vc = '{req_data.c_x, req_data.c_y, req_data.c_z};
      for (int k = 0; k < 3; k++) begin
         e0_in[k] = $signed({vb[k][COORD_WIDTH-1], vb[k]})
                  - $signed({va[k][COORD_WIDTH-1], va[k]});
         e1_in[k] = $signed({vc[k][COORD_WIDTH-1], vc[k]})
                  - $signed({va[k][COORD_WIDTH-1], va[k]});
      end
      p_in[0] = e0_ff[1] * e1_ff[2];
      p_in[1] = e0_ff[2] * e1_ff[1];
      p_in[2] = e0_ff[2] * e1_ff[0];
      p_in[3] = e0_ff[0] * e1_ff[2];
      p_in[4] = e0_ff[0] * e1_ff[1];
      p_in[5] = e0_ff[1] * e1_ff[0];
   end

   always_comb begin
      mid_data.n_x = $signed({p_ff[0][PROD_W-1], p_ff[0]})
                   - $signed({p_ff[1][PROD_W-1], p_ff[1]});
      mid_data.n_y = $signed({p_ff[2][PROD_W-1], p_ff[2]})
                   - $signed({p_ff[3][PROD_W-1], p_ff[3]});
      mid_data.n_z = $signed({p_ff[4][PROD_W-1], p_ff[4]})
                   - $signed({p_ff[5][PROD_W-1], p_ff[5]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= push;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e0_ff <= e0_in;
         e1_ff <= e1_in;
         p_ff  <= p_in;
      end
   end

endmodule

// File: rtl/tun_back.sv
// back end: scaling, squared length, pipelined square root and divide
// depends on tun_pkg; drains the middle queue into the result queue
module tun_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_vld,
   input  tun_pkg::tun_cross_type in_data,
   output logic                   in_take,
   output logic                   out_push,
   output tun_pkg::tun_rsp_type   out_data
);
   import tun_pkg::*;

   logic signed [CROSS_W-1:0] nc [3];

   // stage 0: sign and magnitude
   logic v0_ff;
   logic [MAG_W-1:0] m0_ff [3], m0_in [3];
   logic ng0_ff [3], ng0_in [3];
   // stage 1: bit length of the largest magnitude
   logic v1_ff;
   logic [MAG_W-1:0] m1_ff [3];
   logic ng1_ff [3];
   logic [LEN_W-1:0] len1_ff, len1_in;
   logic [MAG_W-1:0] or0;
   // stage 2: scaled magnitudes
   logic v2_ff, dg2_ff, dg2_in;
   logic [SCALE_W-1:0] s2_ff [3], s2_in [3];
   logic ng2_ff [3];
   // stage 3: squares
   logic v3_ff, dg3_ff;
   logic [SQ_W-1:0] sq3_ff [3], sq3_in [3];
   logic [SCALE_W-1:0] s3_ff [3];
   logic ng3_ff [3];

   // square root pipeline, one result bit per stage
   logic              rv_ff   [ROOT_W+1];
   logic              rdg_ff  [ROOT_W+1];
   logic [SUM_W-1:0]  rad_ff  [ROOT_W+1], rad_in  [ROOT_W+1];
   logic [REM_W-1:0]  rrem_ff [ROOT_W+1], rrem_in [ROOT_W+1];
   logic [ROOT_W-1:0] root_ff [ROOT_W+1], root_in [ROOT_W+1];
   logic [SCALE_W-1:0] rs_ff  [ROOT_W+1][3];
   logic              rng_ff  [ROOT_W+1][3];

   // divide pipeline, one quotient bit per stage and lane
   logic              dv_ff   [Q_W+1];
   logic              ddg_ff  [Q_W+1];
   logic [ROOT_W-1:0] dl_ff   [Q_W+1];
   logic [NUM_W-1:0]  drem_ff [Q_W+1][3], drem_in [Q_W+1][3];
   logic [Q_W-1:0]    dq_ff   [Q_W+1][3], dq_in   [Q_W+1][3];
   logic              dng_ff  [Q_W+1][3];

   logic signed [OUT_WIDTH-1:0] res [3];

   assign in_take  = en && in_vld;
   assign out_push = en && dv_ff[Q_W];

   always_comb begin
      nc = '{in_data.n_x, in_data.n_y, in_data.n_z};
      for (int k = 0; k < 3; k++) begin
         ng0_in[k] = nc[k][CROSS_W-1];
         m0_in[k]  = ng0_in[k] ? MAG_W'(-nc[k]) : MAG_W'(nc[k]);
      end
      or0     = m0_ff[0] | m0_ff[1] | m0_ff[2];
      len1_in = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (or0[b]) begin
            len1_in = LEN_W'(b + 1);
         end
      end
      // magnitude times 2^(31 - len), truncated toward zero
      for (int k = 0; k < 3; k++) begin
         s2_in[k]  = SCALE_W'({m1_ff[k], {SCALE_W{1'b0}}} >> len1_ff);
         sq3_in[k] = SQ_W'(s2_ff[k]) * SQ_W'(s2_ff[k]);
      end
      dg2_in = (len1_ff == '0);
   end

   always_comb begin
      rad_in[0]  = SUM_W'(sq3_ff[0]) + SUM_W'(sq3_ff[1]) + SUM_W'(sq3_ff[2]);
      rrem_in[0] = '0;
      root_in[0] = '0;
   end

   for (genvar j = 0; j < ROOT_W; j++) begin : g_root
      logic [REM_W+1:0] trial, sub;
      always_comb begin
         trial = {rrem_ff[j], rad_ff[j][SUM_W-1 -: 2]};
         sub   = (REM_W + 2)'({root_ff[j], 2'b01});
         rad_in[j+1] = rad_ff[j] << 2;
         if (trial >= sub) begin
            rrem_in[j+1] = REM_W'(trial - sub);
            root_in[j+1] = {root_ff[j][ROOT_W-2:0], 1'b1};
         end else begin
            rrem_in[j+1] = REM_W'(trial);
            root_in[j+1] = {root_ff[j][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         drem_in[0][k] = (NUM_W'(rs_ff[ROOT_W][k]) << NORMAL_FRAC_BITS)
                       + NUM_W'(root_ff[ROOT_W] >> 1);
         dq_in[0][k]   = '0;
      end
   end

   for (genvar i = 0; i < Q_W; i++) begin : g_div
      localparam int SH = Q_W - 1 - i;
      logic [NUM_W-1:0] dsr;
      always_comb begin
         dsr = NUM_W'(dl_ff[i]) << SH;
         for (int k = 0; k < 3; k++) begin
            drem_in[i+1][k] = drem_ff[i][k];
            dq_in[i+1][k]   = dq_ff[i][k];
            if (drem_ff[i][k] >= dsr) begin
               drem_in[i+1][k]   = drem_ff[i][k] - dsr;
               dq_in[i+1][k][SH] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         res[k] = dng_ff[Q_W][k] ? -$signed(OUT_WIDTH'(dq_ff[Q_W][k]))
                                 :  $signed(OUT_WIDTH'(dq_ff[Q_W][k]));
         if (ddg_ff[Q_W]) begin
            res[k] = '0;
         end
      end
      out_data.normal_x   = res[0];
      out_data.normal_y   = res[1];
      out_data.normal_z   = res[2];
      out_data.degenerate = ddg_ff[Q_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int j = 0; j <= ROOT_W; j++) begin
            rv_ff[j] <= 1'b0;
         end
         for (int i = 0; i <= Q_W; i++) begin
            dv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v0_ff    <= in_vld;
         v1_ff    <= v0_ff;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         rv_ff[0] <= v3_ff;
         for (int j = 0; j < ROOT_W; j++) begin
            rv_ff[j+1] <= rv_ff[j];
         end
         dv_ff[0] <= rv_ff[ROOT_W];
         for (int i = 0; i < Q_W; i++) begin
            dv_ff[i+1] <= dv_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m0_ff   <= m0_in;
         ng0_ff  <= ng0_in;
         m1_ff   <= m0_ff;
         ng1_ff  <= ng0_ff;
         len1_ff <= len1_in;
         s2_ff   <= s2_in;
         ng2_ff  <= ng1_ff;
         dg2_ff  <= dg2_in;
         sq3_ff  <= sq3_in;
         s3_ff   <= s2_ff;
         ng3_ff  <= ng2_ff;
         dg3_ff  <= dg2_ff;

         rad_ff[0]  <= rad_in[0];
         rrem_ff[0] <= rrem_in[0];
         root_ff[0] <= root_in[0];
         rs_ff[0]   <= s3_ff;
         rng_ff[0]  <= ng3_ff;
         rdg_ff[0]  <= dg3_ff;
         for (int j = 0; j < ROOT_W; j++) begin
            rad_ff[j+1]  <= rad_in[j+1];
            rrem_ff[j+1] <= rrem_in[j+1];
            root_ff[j+1] <= root_in[j+1];
            rs_ff[j+1]   <= rs_ff[j];
            rng_ff[j+1]  <= rng_ff[j];
            rdg_ff[j+1]  <= rdg_ff[j];
         end

         dl_ff[0]   <= root_ff[ROOT_W];
         drem_ff[0] <= drem_in[0];
         dq_ff[0]   <= dq_in[0];
         dng_ff[0]  <= rng_ff[ROOT_W];
         ddg_ff[0]  <= rdg_ff[ROOT_W];
         for (int i = 0; i < Q_W; i++) begin
            dl_ff[i+1]   <= dl_ff[i];
            drem_ff[i+1] <= drem_in[i+1];
            dq_ff[i+1]   <= dq_in[i+1];
            dng_ff[i+1]  <= dng_ff[i];
            ddg_ff[i+1]  <= ddg_ff[i];
         end
      end
   end

endmodule

// File: tb/sv/triangle_unit_normal_core_tb.sv
// self-checking testbench for triangle_unit_normal_core: directed, random and back-pressure tests
// depends on tun_pkg and the block's rtl; predicts each unit normal with exact integer maths
`timescale 1ns / 1ps

module triangle_unit_normal_core_tb;
   import tun_pkg::*;

   localparam int REQ_BITS = $bits(tun_req_type);

   logic        clock;
   logic        reset;
   logic        push;
   tun_req_type req_data;
   logic        full;
   logic        empty;
   logic        pop;
   tun_rsp_type rsp_data;

   tun_rsp_type normals_due[$];
   int          error_count;
   int          triangles_sent;
   int          normals_seen;
   int          flat_seen;
   int          hold_request;
   int          hold_left;
   int          pop_phase;

   triangle_unit_normal_core DUT (
      .clock(clock), .reset(reset), .push(push), .req_data(req_data),
      .full(full), .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int bit_length(longint unsigned v);
      int n;
      n = 0;
      while (v != 0) begin
         n++;
         v = v >> 1;
      end
      return n;
   endfunction

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned cand;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         cand = r | (64'd1 << i);
         if (cand * cand <= v) r = cand;
      end
      return r;
   endfunction

   function automatic tun_rsp_type face_normal(tun_req_type t);
      longint          e0 [3];
      longint          e1 [3];
      longint          nv [3];
      longint unsigned mag [3];
      longint unsigned sc [3];
      longint unsigned sum;
      longint unsigned root;
      longint unsigned q;
      logic [OUT_WIDTH-1:0] comp [3];
      int              maxlen;
      tun_rsp_type     r;
      e0[0] = longint'(t.b_x) - longint'(t.a_x);
      e0[1] = longint'(t.b_y) - longint'(t.a_y);
      e0[2] = longint'(t.b_z) - longint'(t.a_z);
      e1[0] = longint'(t.c_x) - longint'(t.a_x);
      e1[1] = longint'(t.c_y) - longint'(t.a_y);
      e1[2] = longint'(t.c_z) - longint'(t.a_z);
      nv[0] = e0[1] * e1[2] - e0[2] * e1[1];
      nv[1] = e0[2] * e1[0] - e0[0] * e1[2];
      nv[2] = e0[0] * e1[1] - e0[1] * e1[0];
      maxlen = 0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = (nv[k] < 0) ? longint'(-nv[k]) : longint'(nv[k]);
         if (bit_length(mag[k]) > maxlen) maxlen = bit_length(mag[k]);
      end
      if (maxlen == 0) begin
         r = '0;
         r.degenerate = 1'b1;
         return r;
      end
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         if (maxlen <= 31) sc[k] = (mag[k] << (31 - maxlen)) & 64'h7FFF_FFFF;
         else              sc[k] = mag[k] >> (maxlen - 31);
         sum += sc[k] * sc[k];
      end
      root = floor_root(sum);
      for (int k = 0; k < 3; k++) begin
         q = ((sc[k] << NORMAL_FRAC_BITS) + (root >> 1)) / root;
         comp[k] = (nv[k] < 0) ? OUT_WIDTH'(-q) : OUT_WIDTH'(q);
      end
      r.normal_x   = comp[0];
      r.normal_y   = comp[1];
      r.normal_z   = comp[2];
      r.degenerate = 1'b0;
      return r;
   endfunction

   // leaves push high so back-to-back transactions need no second assignment
   task automatic send_triangle(tun_req_type t);
      push     <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (full);
      normals_due.insert(normals_due.size(), face_normal(t));
      triangles_sent++;
   endtask

   task automatic idle_sender(int cycles);
      push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      idle_sender(1);
      while (normals_due.size() != 0) @(posedge clock);
   endtask

   function automatic tun_req_type make_triangle(int a, int b, int c, int d, int e,
                                                 int f, int g, int h, int i);
      tun_req_type t;
      t.a_x = COORD_WIDTH'(a); t.a_y = COORD_WIDTH'(b); t.a_z = COORD_WIDTH'(c);
      t.b_x = COORD_WIDTH'(d); t.b_y = COORD_WIDTH'(e); t.b_z = COORD_WIDTH'(f);
      t.c_x = COORD_WIDTH'(g); t.c_y = COORD_WIDTH'(h); t.c_z = COORD_WIDTH'(i);
      return t;
   endfunction

   function automatic tun_req_type random_triangle();
      tun_req_type t;
      int          pick;
      int          base;
      pick = $urandom_range(0, 9);
      t = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
      if (pick == 0) begin
         // flat: two vertices coincide
         if ($urandom_range(0, 1)) {t.b_x, t.b_y, t.b_z} = {t.a_x, t.a_y, t.a_z};
         else                      {t.c_x, t.c_y, t.c_z} = {t.b_x, t.b_y, t.b_z};
      end else if (pick == 1) begin
         // small triangle around a random point, tiny components likely
         base = int'($urandom_range(0, 65535)) - 32768;
         t = make_triangle(base, base, base,
                           base + $urandom_range(0, 3), base + $urandom_range(0, 1), base,
                           base + $urandom_range(0, 1), base, base + $urandom_range(0, 3));
      end else if (pick == 2) begin
         t.a_z = t.b_z;
         t.c_z = t.b_z;
      end
      return t;
   endfunction

   // receiver: alternates full-rate and stalling phases, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         pop       <= 1'b0;
         hold_left <= 0;
         pop_phase <= 0;
      end else begin
         pop_phase <= pop_phase + 1;
         if (hold_request != 0) begin
            hold_left    <= hold_request;
            hold_request  = 0;
            pop          <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
         end else if (pop_phase[6]) begin
            pop <= ($urandom_range(0, 3) != 0);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      tun_rsp_type want;
      if (!reset && pop && !empty) begin
         normals_seen++;
         if (normals_due.size() == 0) begin
            $display("%0t: unexpected transaction, got %h", $time, rsp_data);
            error_count++;
         end else begin
            want = normals_due.pop_front();
            if (want.degenerate) flat_seen++;
            if (rsp_data.normal_x !== want.normal_x) begin
               $display("%0t: normal_x expected %0d actual %0d", $time,
                        want.normal_x, rsp_data.normal_x);
               error_count++;
            end
            if (rsp_data.normal_y !== want.normal_y) begin
               $display("%0t: normal_y expected %0d actual %0d", $time,
                        want.normal_y, rsp_data.normal_y);
               error_count++;
            end
            if (rsp_data.normal_z !== want.normal_z) begin
               $display("%0t: normal_z expected %0d actual %0d", $time,
                        want.normal_z, rsp_data.normal_z);
               error_count++;
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               $display("%0t: degenerate expected %0b actual %0b", $time,
                        want.degenerate, rsp_data.degenerate);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed();
      send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0));
      send_triangle(make_triangle(0, 0, 0, 0, 0, 256, 256, 0, 0));
      send_triangle(make_triangle(0, 0, 0, 0, 256, 0, 0, 0, 256));
      send_triangle(make_triangle(-32768, -32768, -32768, 32767, -32768, -32768,
                                  -32768, 32767, -32768));
      send_triangle(make_triangle(32767, 32767, 32767, -32768, 32767, 32767,
                                  32767, -32768, 32767));
      send_triangle(make_triangle(-32768, -32768, -32768, 32767, 32767, -32768,
                                  -32768, 32767, 32767));
      send_triangle(make_triangle(32767, 32767, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767));
      send_triangle(make_triangle(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768));
      // collinear
      send_triangle(make_triangle(0, 0, 0, 100, 200, 300, 200, 400, 600));
      send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
      // two components far smaller than the third
      send_triangle(make_triangle(0, 0, 0, 32767, 0, 1, 0, 32767, 0));
      send_triangle(make_triangle(0, 0, 0, -32768, 1, 0, 0, -32768, 1));
      send_triangle(make_triangle(-1, -1, -1, 0, -1, -1, -1, 0, -1));
      send_triangle(make_triangle(5, -7, 9, -300, 1200, 17, 9999, -4, -20000));
      idle_sender(1);
   endtask

   task automatic test_random(int count);
      int burst;
      int left;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && left > 0) begin
            send_triangle(random_triangle());
            burst--;
            left--;
         end
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 9));
      end
      idle_sender(1);
   endtask

   task automatic test_backpressure();
      hold_request = 400;
      @(posedge clock);
      repeat (80) send_triangle(random_triangle());
      wait_drained();
   endtask

   initial begin
      reset        = 1'b1;
      push         = 1'b0;
      req_data     = '0;
      error_count  = 0;
      hold_request = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      wait_drained();
      test_random(500);
      test_backpressure();
      test_random(450);
      wait_drained();
      repeat (150) @(posedge clock);

      $display("covered %0d triangles, %0d normals checked, %0d flat ones",
               triangles_sent, normals_seen, flat_seen);
      $display("includes random bursts, receiver stalls and a long hold-off filling the queues");
      if (error_count == 0 && normals_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
